// ===== hdl/kcp_pkg.sv =====
// ----------------------------------------------------------------------------
// kcp_pkg
// Shared types, constants and keyword tables of the keyword command parser.
// ----------------------------------------------------------------------------
package kcp_pkg;

    localparam int BUFFER_CHARS = 20;
    localparam int CAPACITY     = BUFFER_CHARS - 1;
    localparam int COUNT_W      = $clog2(BUFFER_CHARS);

    localparam logic [7:0] CHAR_TERM  = 8'h3B; // ';'
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CHAR_ONE   = 8'h31; // '1'
    localparam logic [7:0] CHAR_THREE = 8'h33; // '3'

    localparam logic [2:0] MODE_LEN  = 3'd4;
    localparam logic [2:0] LEVEL_LEN = 3'd5;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_AUTO  = 2'd1;
    localparam logic [1:0] CMD_HAND  = 2'd2;
    localparam logic [1:0] CMD_LEVEL = 2'd3;

    // Item passed from the front part to the back part.
    typedef struct packed {
        logic       term;
        logic       overflowed;
        logic [7:0] data;
    } t_token;

    typedef struct packed {
        logic [1:0] command_kind;
        logic [1:0] fan_level;
        logic       mode_is_auto;
        logic       message_overflowed;
    } t_result;

    // "MODE"
    function automatic logic [7:0] mode_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h4D;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h44;
            3'd3:    c = 8'h45;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "LEVEL"
    function automatic logic [7:0] level_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h4C;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h56;
            3'd3:    c = 8'h45;
            3'd4:    c = 8'h4C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/kcp_front.sv =====
// ----------------------------------------------------------------------------
// kcp_front
// Accepts received bytes, tracks message capacity and end of text, and
// forwards searchable bytes and terminators as tokens.
// ----------------------------------------------------------------------------
module kcp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_q_full,
    output logic           o_tok_push,
    output kcp_pkg::t_token o_tok
);
    import kcp_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_text_ended, n_text_ended;
    logic               r_overflow, n_overflow;
    logic               accept;

    assign full   = i_q_full;
    assign accept = push & ~i_q_full;

    always_comb begin
        n_count      = r_count;
        n_text_ended = r_text_ended;
        n_overflow   = r_overflow;
        o_tok_push   = 1'b0;
        o_tok.term       = 1'b0;
        o_tok.overflowed = r_overflow;
        o_tok.data       = i_rx_byte;
        if (accept) begin
            if (i_rx_byte == CHAR_TERM) begin
                o_tok_push   = 1'b1;
                o_tok.term   = 1'b1;
                n_count      = '0;
                n_text_ended = 1'b0;
                n_overflow   = 1'b0;
            end else if (r_count >= COUNT_W'(CAPACITY)) begin
                n_overflow = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
                if (!r_text_ended) begin
                    if (i_rx_byte == CHAR_NUL) begin
                        n_text_ended = 1'b1;
                    end else begin
                        o_tok_push = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_text_ended <= 1'b0;
            r_overflow   <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_text_ended <= n_text_ended;
            r_overflow   <= n_overflow;
        end
    end

endmodule

// ===== hdl/kcp_queue.sv =====
// ----------------------------------------------------------------------------
// kcp_queue
// Two-entry token queue between the front and back parts.
// ----------------------------------------------------------------------------
module kcp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kcp_pkg::t_token i_tok,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output kcp_pkg::t_token o_tok
);
    import kcp_pkg::*;

    t_token     r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tok   = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/kcp_back.sv =====
// ----------------------------------------------------------------------------
// kcp_back
// Runs the keyword matchers, decides the command on a terminator, keeps the
// fan mode and buffers results for transfer.
// ----------------------------------------------------------------------------
module kcp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    input  kcp_pkg::t_token i_tok,
    output logic            o_tok_pop,
    output logic            empty,
    input  logic            pop,
    output kcp_pkg::t_result o_result
);
    import kcp_pkg::*;

    logic [2:0] r_mode_prog, n_mode_prog;
    logic       r_mode_seen, n_mode_seen;
    logic [7:0] r_mode_digit, n_mode_digit;
    logic       r_mode_taken, n_mode_taken;
    logic [2:0] r_lvl_prog, n_lvl_prog;
    logic       r_lvl_seen, n_lvl_seen;
    logic [7:0] r_lvl_digit, n_lvl_digit;
    logic       r_lvl_taken, n_lvl_taken;
    logic       r_fan_auto, n_fan_auto;

    t_result    r_out [2];
    logic       r_out_wr, r_out_rd;
    logic [1:0] r_out_cnt;
    logic       out_push, out_pop;
    t_result    result;
    logic [7:0] c;

    assign c         = i_tok.data;
    assign o_tok_pop = i_tok_valid & (~i_tok.term | (r_out_cnt != 2'd2));
    assign out_push  = o_tok_pop & i_tok.term;
    assign empty     = (r_out_cnt == 2'd0);
    assign out_pop   = pop & ~empty;
    assign o_result  = r_out[r_out_rd];

    always_comb begin
        n_mode_prog  = r_mode_prog;
        n_mode_seen  = r_mode_seen;
        n_mode_digit = r_mode_digit;
        n_mode_taken = r_mode_taken;
        n_lvl_prog   = r_lvl_prog;
        n_lvl_seen   = r_lvl_seen;
        n_lvl_digit  = r_lvl_digit;
        n_lvl_taken  = r_lvl_taken;
        n_fan_auto   = r_fan_auto;
        result.command_kind       = CMD_NONE;
        result.fan_level          = 2'd0;
        result.message_overflowed = i_tok.overflowed;
        if (o_tok_pop && i_tok.term) begin
            if (r_mode_seen) begin
                if (r_mode_taken && r_mode_digit == CHAR_ZERO) begin
                    n_fan_auto          = 1'b1;
                    result.command_kind = CMD_AUTO;
                end else if (r_mode_taken && r_mode_digit == CHAR_ONE) begin
                    n_fan_auto          = 1'b0;
                    result.command_kind = CMD_HAND;
                end
            end else if (r_lvl_seen && r_lvl_taken && r_lvl_digit >= CHAR_ZERO
                         && r_lvl_digit <= CHAR_THREE) begin
                result.command_kind = CMD_LEVEL;
                result.fan_level    = r_lvl_digit[1:0];
            end
            n_mode_prog  = '0;
            n_mode_seen  = 1'b0;
            n_mode_taken = 1'b0;
            n_lvl_prog   = '0;
            n_lvl_seen   = 1'b0;
            n_lvl_taken  = 1'b0;
        end else if (o_tok_pop) begin
            if (r_mode_seen) begin
                if (!r_mode_taken) begin
                    n_mode_digit = c;
                    n_mode_taken = 1'b1;
                end
            end else begin
                if (c == mode_char(r_mode_prog)) begin
                    n_mode_prog = r_mode_prog + 3'd1;
                end else begin
                    n_mode_prog = {2'b00, c == mode_char(3'd0)};
                end
                n_mode_seen = (n_mode_prog == MODE_LEN);
            end
            if (r_lvl_seen) begin
                if (!r_lvl_taken) begin
                    n_lvl_digit = c;
                    n_lvl_taken = 1'b1;
                end
            end else begin
                if (c == level_char(r_lvl_prog)) begin
                    n_lvl_prog = r_lvl_prog + 3'd1;
                end else begin
                    n_lvl_prog = {2'b00, c == level_char(3'd0)};
                end
                n_lvl_seen = (n_lvl_prog == LEVEL_LEN);
            end
        end
        result.mode_is_auto = n_fan_auto;
    end

    always_ff @(posedge i_clk) begin
        r_mode_digit <= n_mode_digit;
        r_lvl_digit  <= n_lvl_digit;
        if (out_push) begin
            r_out[r_out_wr] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_prog  <= '0;
            r_mode_seen  <= 1'b0;
            r_mode_taken <= 1'b0;
            r_lvl_prog   <= '0;
            r_lvl_seen   <= 1'b0;
            r_lvl_taken  <= 1'b0;
            r_fan_auto   <= 1'b1;
            r_out_wr     <= 1'b0;
            r_out_rd     <= 1'b0;
            r_out_cnt    <= 2'd0;
        end else begin
            r_mode_prog  <= n_mode_prog;
            r_mode_seen  <= n_mode_seen;
            r_mode_taken <= n_mode_taken;
            r_lvl_prog   <= n_lvl_prog;
            r_lvl_seen   <= n_lvl_seen;
            r_lvl_taken  <= n_lvl_taken;
            r_fan_auto   <= n_fan_auto;
            if (out_push) begin
                r_out_wr <= ~r_out_wr;
            end
            if (out_pop) begin
                r_out_rd <= ~r_out_rd;
            end
            case ({out_push, out_pop})
                2'b10:   r_out_cnt <= r_out_cnt + 2'd1;
                2'b01:   r_out_cnt <= r_out_cnt - 2'd1;
                default: r_out_cnt <= r_out_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/keyword_command_parser.sv =====
// ----------------------------------------------------------------------------
// keyword_command_parser
// Collects bytes up to ';' and gives one fan command result per message.
//
// Channel   Direction  Handshake        Payload
// input     in         push / full      i_rx_byte
// result    out        empty / pop      o_command_kind, o_fan_level,
//                                       o_mode_is_auto, o_message_overflowed
//
// One byte is taken per cycle while full is low; after its ';' is
// transferred, a result passes the token queue and then the back stage
// result buffer, and it waits behind any token ahead of it.
// Reset is synchronous and clears both queues; the fan mode returns to auto.
// Two-entry queues sit between front and back and on the result side, so a
// stalled reader backs up into full only once both have filled.
// ----------------------------------------------------------------------------
module keyword_command_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_command_kind,
    output logic [1:0] o_fan_level,
    output logic       o_mode_is_auto,
    output logic       o_message_overflowed
);
    import kcp_pkg::*;

    logic    tok_push, q_full, q_valid, tok_pop;
    t_token  tok_in, tok_out;
    t_result result;

    kcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_tok_push (tok_push),
        .o_tok      (tok_in)
    );

    kcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_tok   (tok_in),
        .o_full  (q_full),
        .i_pop   (tok_pop),
        .o_valid (q_valid),
        .o_tok   (tok_out)
    );

    kcp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (tok_out),
        .o_tok_pop   (tok_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result)
    );

    assign o_command_kind       = result.command_kind;
    assign o_fan_level          = result.fan_level;
    assign o_mode_is_auto       = result.mode_is_auto;
    assign o_message_overflowed = result.message_overflowed;

endmodule
